// ===== hw/rtl/pss_pkg.sv =====
// pss_pkg: shared types and constants for the peak-sum spectrum error block
// no dependencies
`timescale 1ns / 1ps
package pss_pkg;
   localparam int unsigned DataW = 32;
   localparam logic [29:0] Kg30 = 30'd1008713097;
   localparam logic [29:0] Kl30 = 30'd683565276;
   localparam logic [30:0] One30 = 31'd1073741824;
   localparam logic [DataW-1:0] I32Max = 32'h7FFF_FFFF;

   typedef enum logic [0:0] {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      REG_PEAK_COUNT   = 1'b0,
      REG_LORENTZ_MASK = 1'b1
   } reg_idx_type;

   // 2^-(2^-j) in q30, j = 1..24
   function automatic logic [30:0] pow_half(input logic [4:0] j);
      logic [30:0] r;
      unique case (j)
         5'd1:  r = 31'd759250125;
         5'd2:  r = 31'd902905651;
         5'd3:  r = 31'd984625594;
         5'd4:  r = 31'd1028218693;
         5'd5:  r = 31'd1050733751;
         5'd6:  r = 31'd1062175492;
         5'd7:  r = 31'd1067943000;
         5'd8:  r = 31'd1070838486;
         5'd9:  r = 31'd1072289173;
         5'd10: r = 31'd1073015252;
         5'd11: r = 31'd1073378477;
         5'd12: r = 31'd1073560135;
         5'd13: r = 31'd1073650976;
         5'd14: r = 31'd1073696399;
         5'd15: r = 31'd1073719111;
         5'd16: r = 31'd1073730468;
         5'd17: r = 31'd1073736146;
         5'd18: r = 31'd1073738985;
         5'd19: r = 31'd1073740404;
         5'd20: r = 31'd1073741114;
         5'd21: r = 31'd1073741469;
         5'd22: r = 31'd1073741647;
         5'd23: r = 31'd1073741735;
         5'd24: r = 31'd1073741780;
         default: r = One30;
      endcase
      return r;
   endfunction
endpackage

// ===== hw/rtl/pss_if.sv =====
// pss_if: valid/ready channel interfaces for request, response and csr writes
// depends on nothing
`timescale 1ns / 1ps
interface pss_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [3:0]  peak_slot;
   logic signed [31:0] peak_center;
   logic signed [31:0] peak_width;
   logic signed [31:0] peak_area;
   logic signed [31:0] sample_energy;
   logic signed [31:0] measured_value;
   logic        last_sample;
   modport source (output valid, operation, peak_slot, peak_center, peak_width,
      peak_area, sample_energy, measured_value, last_sample, input ready);
   modport sink (input valid, operation, peak_slot, peak_center, peak_width,
      peak_area, sample_energy, measured_value, last_sample, output ready);
endinterface

interface pss_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] model_value;
   logic [30:0] abs_error;
   logic [30:0] mean_error;
   logic        mean_valid;
   logic        bad_width;
   modport source (output valid, model_value, abs_error, mean_error, mean_valid,
      bad_width, input ready);
   modport sink (input valid, model_value, abs_error, mean_error, mean_valid,
      bad_width, output ready);
endinterface

interface pss_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pss_ram.sv =====
// pss_ram: generic simple dual-port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
module pss_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hw/rtl/peak_sum_spectrum_error.sv =====
// peak_sum_spectrum_error: one shared 33x33 multiplier and one restoring divider under a
// sequencer, one item at a time; load result 129 cycles after accept (two 64-step divisions)
// sample result 3 cycles plus 23 per gaussian or 70 per lorentzian peak after accept, 64 more
// on a last sample for the mean; next item taken the cycle after the result is accepted
// synchronous active-high reset clears config, error sum, tally and control
// depends on pss_pkg, pss_if, pss_ram
`timescale 1ns / 1ps
module peak_sum_spectrum_error #(
   parameter int unsigned MAX_PEAKS  = 16,
   parameter int unsigned FRAC_BITS  = 16,
   parameter int unsigned COUNT_BITS = 20
) (
   input logic clock,
   input logic reset,
   pss_req_if.sink   req_bus,
   pss_rsp_if.source rsp_bus,
   pss_csr_if.sink   csr_bus
);
   localparam int unsigned SlotW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int unsigned ExpSteps = (FRAC_BITS < 24) ? FRAC_BITS : 24;
   localparam logic [51:0] SumMax = {52{1'b1}};
   localparam logic [COUNT_BITS-1:0] TallyMax = {COUNT_BITS{1'b1}};

   typedef enum logic [4:0] {
      S_IDLE, S_LD_DIV1, S_LD_DIV2, S_LD_WR,
      S_PK_RD, S_PK_WAIT, S_PK_U, S_PK_T, S_PK_M, S_PK_EXP, S_PK_EXPSH,
      S_PK_LDIV, S_PK_ACC, S_SUM, S_MEAN, S_OUT
   } state_type;

   state_type state_ff;
   logic [4:0]  peak_count_ff;
   logic [15:0] lorentz_mask_ff;
   logic [51:0] error_sum_ff;
   logic [COUNT_BITS-1:0] tally_ff;

   // item latch
   logic        last_ff;
   logic [3:0]  slot_ff;
   logic [31:0] center_ff, area_ff, energy_ff, meas_ff;

   // shared divider: 64-bit dividend / 51-bit divisor, one bit a cycle
   logic [63:0] dq_ff;    // dividend shifting into quotient
   logic [51:0] drem_ff;
   logic [50:0] dvs_ff;
   logic [6:0]  dcnt_ff;
   logic [52:0] dtrial;
   logic [51:0] dshift;
   assign dshift = {drem_ff[50:0], dq_ff[63]};
   assign dtrial = {1'b0, dshift} - {2'b00, dvs_ff};

   // shared multiplier
   logic [32:0] ma, mb;
   logic [65:0] mprod;
   assign mprod = ma * mb;

   logic [32:0] w_ff;
   logic [31:0] scale_st_ff;
   logic [6:0]  step_ff;
   logic [SlotW:0] peak_ff;
   logic [31:0] cen_rd, scl_rd, rate_rd;
   logic [31:0] u_ff, m_ff;
   logic [49:0] t4_ff;
   logic [30:0] r_ff;
   logic [33:0] c_ff;
   logic signed [38:0] sum_ff;
   logic [31:0] model_ff;
   logic [30:0] err_ff, mean_ff;
   logic        bad_ff, mvalid_ff, rsp_valid_ff;

   logic [SlotW-1:0] rd_addr;
   logic [SlotW-1:0] wr_addr;
   logic             wr_en;
   assign rd_addr = peak_ff[SlotW-1:0];
   assign wr_addr = SlotW'(slot_ff);
   assign wr_en = (state_ff == S_LD_WR) && (32'(slot_ff) < MAX_PEAKS);

   pss_ram #(.WIDTH(32), .DEPTH(MAX_PEAKS)) u_cen (.clock, .wr_en, .wr_addr,
      .wr_data(center_ff), .rd_addr, .rd_data(cen_rd));
   pss_ram #(.WIDTH(32), .DEPTH(MAX_PEAKS)) u_scl (.clock, .wr_en, .wr_addr,
      .wr_data(scale_st_ff), .rd_addr, .rd_data(scl_rd));
   pss_ram #(.WIDTH(32), .DEPTH(MAX_PEAKS)) u_rate (.clock, .wr_en, .wr_addr,
      .wr_data(u_ff), .rd_addr, .rd_data(rate_rd));

   logic [4:0] n_eff;
   assign n_eff = (32'(peak_count_ff) < MAX_PEAKS) ? peak_count_ff : 5'(MAX_PEAKS);

   logic [32:0] d_abs, s_abs, w_abs;
   logic signed [32:0] d_sig;
   assign d_sig = 33'(signed'(energy_ff)) - 33'(signed'(cen_rd));
   assign d_abs = d_sig[32] ? 33'(-d_sig) : 33'(d_sig);
   assign s_abs = scl_rd[31] ? 33'(-33'(signed'(scl_rd))) : {1'b0, scl_rd};
   assign w_abs = req_bus.peak_width[31] ? 33'(-33'(req_bus.peak_width))
                                         : {1'b0, req_bus.peak_width};

   logic [4:0] exp_j;
   assign exp_j = 5'(step_ff);

   logic lor_cur;
   assign lor_cur = (32'(peak_ff) < 16) && lorentz_mask_ff[4'(peak_ff)];

   always_comb begin
      ma = '0;
      mb = '0;
      unique case (state_ff)
         S_PK_U:   begin ma = d_abs; mb = {1'b0, rate_rd}; end
         S_PK_T:   begin ma = {1'b0, u_ff}; mb = {1'b0, u_ff}; end
         S_PK_M:   begin
            ma = s_abs;
            mb = lor_cur ? 33'(pss_pkg::Kl30) : 33'(pss_pkg::Kg30);
         end
         S_PK_EXP: begin ma = 33'(r_ff); mb = 33'(pss_pkg::pow_half(exp_j)); end
         S_PK_ACC: begin ma = {1'b0, m_ff}; mb = 33'(r_ff); end
         default:  begin ma = '0; mb = '0; end
      endcase
   end

   logic [49:0] ip_sh;
   assign ip_sh = t4_ff >> FRAC_BITS;

   assign req_bus.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.model_value = model_ff;
   assign rsp_bus.abs_error = err_ff;
   assign rsp_bus.mean_error = mean_ff;
   assign rsp_bus.mean_valid = mvalid_ff;
   assign rsp_bus.bad_width = bad_ff;

   logic signed [38:0] clamp_lo, clamp_hi;
   assign clamp_hi = 39'sd2147483647;
   assign clamp_lo = -39'sd2147483648;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         peak_count_ff <= '0;
         lorentz_mask_ff <= '0;
         error_sum_ff <= '0;
         tally_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            unique case (pss_pkg::reg_idx_type'(csr_bus.index))
               pss_pkg::REG_PEAK_COUNT:   peak_count_ff <= csr_bus.data[4:0];
               pss_pkg::REG_LORENTZ_MASK: lorentz_mask_ff <= csr_bus.data[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid && req_bus.ready) begin
                  last_ff <= req_bus.last_sample;
                  slot_ff <= req_bus.peak_slot;
                  center_ff <= req_bus.peak_center;
                  area_ff <= req_bus.peak_area;
                  energy_ff <= req_bus.sample_energy;
                  meas_ff <= req_bus.measured_value;
                  w_ff <= w_abs;
                  sum_ff <= '0;
                  peak_ff <= '0;
                  if (req_bus.operation == pss_pkg::OP_LOAD) begin
                     // scale = |area| << F / w
                     dq_ff <= 64'({1'b0, req_bus.peak_area[31] ?
                        33'(-33'(req_bus.peak_area)) : {1'b0, req_bus.peak_area}})
                        << FRAC_BITS;
                     drem_ff <= '0;
                     dvs_ff <= 51'(w_abs);
                     dcnt_ff <= '0;
                     state_ff <= S_LD_DIV1;
                  end else begin
                     state_ff <= S_PK_RD;
                  end
               end
            end
            S_LD_DIV1, S_LD_DIV2, S_PK_LDIV, S_MEAN: begin
               if (dcnt_ff != 7'd63) begin
                  if (!dtrial[52]) begin
                     drem_ff <= dtrial[51:0];
                     dq_ff <= {dq_ff[62:0], 1'b1};
                  end else begin
                     drem_ff <= dshift;
                     dq_ff <= {dq_ff[62:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 7'd1;
               end else begin
                  unique case (state_ff)
                     S_LD_DIV1: begin
                        begin : sc_fix
                           logic [63:0] q;
                           logic [31:0] s;
                           q = dtrial[52] ? {dq_ff[62:0], 1'b0} : {dq_ff[62:0], 1'b1};
                           s = (q > 64'(pss_pkg::I32Max)) ? pss_pkg::I32Max : q[31:0];
                           scale_st_ff <= area_ff[31] ? 32'(-s) : s;
                        end
                        state_ff <= S_LD_DIV2;
                        dq_ff <= 64'd1 << (2 * FRAC_BITS);
                        drem_ff <= '0;
                        dcnt_ff <= '0;
                     end
                     S_LD_DIV2: begin
                        begin : rt_fix
                           logic [63:0] q;
                           q = dtrial[52] ? {dq_ff[62:0], 1'b0} : {dq_ff[62:0], 1'b1};
                           u_ff <= (w_ff == '0) ? 32'h0 :
                              (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                        end
                        if (w_ff == '0) begin
                           scale_st_ff <= '0;
                        end
                        state_ff <= S_LD_WR;
                     end
                     S_PK_LDIV: begin
                        c_ff <= dtrial[52] ? {dq_ff[32:0], 1'b0} : {dq_ff[32:0], 1'b1};
                        state_ff <= S_PK_ACC;
                     end
                     default: begin
                        begin : mn_fix
                           logic [63:0] q;
                           q = dtrial[52] ? {dq_ff[62:0], 1'b0} : {dq_ff[62:0], 1'b1};
                           mean_ff <= (q > 64'(pss_pkg::I32Max)) ? 31'h7FFF_FFFF : q[30:0];
                        end
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_LD_WR: begin
               model_ff <= '0;
               err_ff <= '0;
               mean_ff <= '0;
               mvalid_ff <= 1'b0;
               bad_ff <= (w_ff == '0);
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_PK_RD: begin
               state_ff <= (5'(peak_ff) < n_eff) ? S_PK_WAIT : S_SUM;
            end
            S_PK_WAIT: state_ff <= S_PK_U;
            S_PK_U: begin
               u_ff <= (mprod[65:FRAC_BITS] > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF
                  : mprod[FRAC_BITS+31:FRAC_BITS];
               state_ff <= S_PK_T;
            end
            S_PK_T: begin
               t4_ff <= 50'(mprod[63:FRAC_BITS]) << 2;
               state_ff <= S_PK_M;
            end
            S_PK_M: begin
               m_ff <= mprod[61:30];
               r_ff <= pss_pkg::One30;
               step_ff <= 7'd1;
               if (lor_cur) begin
                  dq_ff <= 64'(mprod[61:30]) << FRAC_BITS;
                  drem_ff <= '0;
                  dvs_ff <= 51'((51'd1 << FRAC_BITS) + 51'(t4_ff));
                  dcnt_ff <= '0;
                  state_ff <= S_PK_LDIV;
               end else begin
                  state_ff <= S_PK_EXP;
               end
            end
            S_PK_EXP: begin
               if (t4_ff[FRAC_BITS - 32'(step_ff)]) begin
                  r_ff <= mprod[60:30];
               end
               step_ff <= step_ff + 7'd1;
               if (32'(step_ff) == ExpSteps) begin
                  state_ff <= S_PK_EXPSH;
               end
            end
            S_PK_EXPSH: begin
               r_ff <= (ip_sh >= 50'd31) ? '0 : r_ff >> ip_sh[4:0];
               state_ff <= S_PK_ACC;
            end
            S_PK_ACC: begin
               begin : acc
                  logic [33:0] c;
                  c = lor_cur ? c_ff : mprod[63:30];
                  sum_ff <= scl_rd[31] ? sum_ff - 39'(c) : sum_ff + 39'(c);
               end
               peak_ff <= peak_ff + 1'b1;
               state_ff <= S_PK_RD;
            end
            S_SUM: begin
               begin : fin
                  logic signed [38:0] s, e;
                  logic [38:0] ea;
                  logic [30:0] er;
                  logic [52:0] ns;
                  logic [COUNT_BITS-1:0] nt;
                  s = (sum_ff > clamp_hi) ? clamp_hi : (sum_ff < clamp_lo) ? clamp_lo : sum_ff;
                  e = 39'(signed'(meas_ff)) - s;
                  ea = e[38] ? 39'(-e) : 39'(e);
                  er = (ea > 39'h7FFF_FFFF) ? 31'h7FFF_FFFF : ea[30:0];
                  ns = 53'(error_sum_ff) + 53'(er);
                  nt = (tally_ff == TallyMax) ? tally_ff : tally_ff + 1'b1;
                  model_ff <= s[31:0];
                  err_ff <= er;
                  bad_ff <= 1'b0;
                  mvalid_ff <= last_ff;
                  mean_ff <= '0;
                  if (last_ff) begin
                     error_sum_ff <= '0;
                     tally_ff <= '0;
                     dq_ff <= {12'd0, ns[52] ? SumMax : ns[51:0]};
                     drem_ff <= '0;
                     dvs_ff <= 51'(nt);
                     dcnt_ff <= '0;
                     state_ff <= S_MEAN;
                  end else begin
                     error_sum_ff <= ns[52] ? SumMax : ns[51:0];
                     tally_ff <= nt;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
